// ----- sv/lgs_pkg.sv -----
package lgs_pkg;

  // Grid limits and derived widths
  localparam int MAX_COLS  = 2048;
  localparam int MAX_ROWS  = 2048;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int DIM_W     = 12;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);

  // Tag of one accepted item, built by the scan counters
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             cur;
    logic             emit;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;
    logic             last;
  } scan_item_t;

  // Clamp a grid dimension to [3, hi]
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    if (v < DIM_MIN) begin
      res = DIM_MIN;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // B3/S23 rule on a 3x3 window, center at bit 4
  function automatic logic life_next(input logic [8:0] win);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        n = n + {3'd0, win[k]};
      end
    end
    return (n == 4'd3) || (win[4] && (n == 4'd2));
  endfunction

endpackage

// ----- sv/life_generation_stencil.sv -----
// One generation of Life (B3/S23) over a grid streamed in raster order, one
// cell per item, with the outer ring of cells held dead. The block takes one
// cell every clock while not stalled; a result for interior cell (r-1, c-1)
// leaves the output register after cell (r, c) is accepted, with its row,
// column and a flag on the last interior cell of the frame. The two rows above
// sit in one 2-bit line buffer memory read and written once per cell at the
// column address; since the grid is at least three columns wide, the write of
// one cell always lands before the next read of the same column. Writing width
// or height (clamped to 3..2048) restarts the frame at cell (0, 0); write them
// only while the block is idle. No clearing pass is needed after reset.
module life_generation_stencil
  import lgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_alive,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_next_alive,
  output logic [ROW_W-1:0]     out_cell_row,
  output logic [COL_W-1:0]     out_cell_col,
  output logic                 out_last_cell
);

  scan_item_t       item;
  logic             take;
  logic             busy;
  logic [1:0]       rd_data;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [1:0]       wr_data;

  assign in_stall = busy;
  assign take     = in_valid && !busy;

  lgs_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .take      (take),
    .in_alive  (in_alive),
    .item      (item)
  );

  lgs_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (item.col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lgs_rule u_rule (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .item           (item),
    .busy           (busy),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_alive (out_next_alive),
    .out_cell_row   (out_cell_row),
    .out_cell_col   (out_cell_col),
    .out_last_cell  (out_last_cell)
  );

endmodule

// ----- sv/lgs_line_buf.sv -----
module lgs_line_buf
  import lgs_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output logic [1:0]       rd_data,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [1:0]       wr_data
);

  // Bit 1: row two above, bit 0: row one above
  logic [1:0] mem [MAX_COLS];
  logic [1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/lgs_scan.sv -----
module lgs_scan
  import lgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output logic                 cfg_ready,
  input  logic                 take,
  input  logic                 in_alive,
  output scan_item_t           item
);

  localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_ROWS);

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_x, row_x, col_inc, row_inc;
  logic             border;
  logic             cfg_hit;

  assign cfg_ready = 1'b1;

  assign col_x   = DIM_W'(col_r);
  assign row_x   = DIM_W'(row_r);
  assign col_inc = col_x + DIM_W'(1);
  assign row_inc = row_x + DIM_W'(1);

  // Classify the arriving cell
  assign border = (row_r == '0) || (col_r == '0) ||
                  (row_inc == height_r) || (col_inc == width_r);

  always_comb begin
    item.col    = col_r;
    item.cur    = border ? 1'b0 : in_alive;
    item.emit   = (row_x >= DIM_W'(2)) && (col_x >= DIM_W'(2));
    item.row_m1 = row_r - ROW_W'(1);
    item.col_m1 = col_r - COL_W'(1);
    item.last   = (row_inc == height_r) && (col_inc == width_r);
  end

  // Register writes restart the frame; accepted items advance the raster
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    cfg_hit    = 1'b0;
    if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH) begin
        width_nxt = clamp_dim(cfg_data, MAX_W);
        cfg_hit   = 1'b1;
      end else if (cfg_index == CFG_HEIGHT) begin
        height_nxt = clamp_dim(cfg_data, MAX_H);
        cfg_hit    = 1'b1;
      end
    end
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      if (col_inc >= width_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= height_r) ? '0 : ROW_W'(row_inc);
      end else begin
        col_nxt = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= MAX_W;
      height_r <= MAX_H;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

// ----- sv/lgs_rule.sv -----
module lgs_rule
  import lgs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  scan_item_t       item,
  output logic             busy,
  input  logic [1:0]       rd_data,
  output logic             wr_en,
  output logic [COL_W-1:0] wr_addr,
  output logic [1:0]       wr_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_next_alive,
  output logic [ROW_W-1:0] out_cell_row,
  output logic [COL_W-1:0] out_cell_col,
  output logic             out_last_cell
);

  logic             s1_valid_r, s1_valid_nxt;
  scan_item_t       s1_item_r;
  logic             fire;
  logic [8:0]       win_r, win_nxt;
  logic [2:0]       new_col;
  logic             out_valid_r, out_valid_nxt;
  logic             next_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             last_r;

  // Advance the waiting item when the output register is free or drains
  assign fire = s1_valid_r && (!out_valid_r || !out_stall);
  assign busy = s1_valid_r && !fire;

  // Column entering the window: row two up, row one up, current row
  assign new_col = {s1_item_r.cur, rd_data[0], rd_data[1]};
  assign win_nxt = {new_col, win_r[8:3]};

  // Shift the buffered rows down at this column
  assign wr_en   = fire;
  assign wr_addr = s1_item_r.col;
  assign wr_data = {rd_data[0], s1_item_r.cur};

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = s1_item_r.emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        win_r <= win_nxt;
      end
    end
  end

  // Stage and output payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_item_r <= item;
    end
    if (fire) begin
      next_r <= life_next(win_nxt);
      row_r  <= s1_item_r.row_m1;
      col_r  <= s1_item_r.col_m1;
      last_r <= s1_item_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_alive = next_r;
  assign out_cell_row   = row_r;
  assign out_cell_col   = col_r;
  assign out_last_cell  = last_r;

endmodule

// ----- sv/lgs_checker.sv -----
module lgs_checker
  import lgs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [DIM_W-1:0]     cfg_data,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_alive,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_next_alive,
  input logic [ROW_W-1:0]     out_cell_row,
  input logic [COL_W-1:0]     out_cell_col,
  input logic                 out_last_cell
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_alive) &&
      $stable(out_cell_row) && $stable(out_cell_col) && $stable(out_last_cell))
    else $error("stalled result changed");

  // Never report a cell in row 0 or column 0
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_row != '0) && (out_cell_col != '0))
    else $error("border cell reported");

  // Back-to-back results walk along one row
  a_row_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid ||
      ((out_cell_col == $past(out_cell_col) + COL_W'(1)) &&
       (out_cell_row == $past(out_cell_row))))
    else $error("results out of raster order");

  // The last cell is followed by a gap before the next frame
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_cell |=> !out_valid)
    else $error("result directly after last cell");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (.*);
